FILE: rtl/swm3_pkg.sv
`default_nettype none

package swm3_pkg;

  localparam int MaxWindow = 16;
  localparam int NumAxes   = 3;
  localparam int DataW     = 32;
  localparam int KeyW      = DataW + 1;
  localparam int LenW      = 5;
  localparam int FillW     = 5;
  localparam int CntW      = $clog2(MaxWindow + 1);
  localparam int IdxW      = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int CmpW      = (CntW > LenW) ? CntW : LenW;
  localparam int TailN     = (MaxWindow > 1) ? MaxWindow - 1 : 1;
  localparam int HiPos     = (MaxWindow > 1) ? 1 : 0;

  localparam logic [LenW-1:0] LenReset = LenW'(3);

  typedef logic [NumAxes-1:0][DataW-1:0] sample_t;
  typedef logic [NumAxes-1:0][KeyW-1:0]  key_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SORT,
    S_SEL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic accept;
    logic load;
    logic sort;
    logic sort_odd;
    logic shift;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [IdxW-1:0] sel_idx;
    logic            out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/swm3_pos_if.sv
`default_nettype none

interface swm3_pos_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

`default_nettype wire

FILE: rtl/swm3_med_if.sv
`default_nettype none

interface swm3_med_if;
  logic        valid;
  logic        ready;
  logic [31:0] med_x;
  logic [31:0] med_y;
  logic [31:0] med_z;
  logic [4:0]  window_fill;

  modport source (output valid, med_x, med_y, med_z, window_fill, input ready);
  modport sink (input valid, med_x, med_y, med_z, window_fill, output ready);
endinterface

`default_nettype wire

FILE: rtl/swm3_cfg_if.sv
`default_nettype none

interface swm3_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] window_length;

  modport source (output valid, window_length, input ready);
  modport sink (input valid, window_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/sliding_window_median_3axis.sv
// Channel   Dir  Handshake      Payload
// pos_i     in   valid/ready    pos_x, pos_y, pos_z (signed Q16.16)
// med_o     out  valid/ready    med_x, med_y, med_z (signed Q16.16), window_fill
// cfg_i     in   valid/ready    window_length (always ready)
//
// Each item is processed to the end before the next item can be taken: a load
// step, sixteen odd-even transposition passes over the window copy, one shift
// per rank below the median, and a final step that picks or averages the median.
// Reset leaves a window of one zero sample and a length of three.
// A result waiting in the output register does not block the next item; the
// block only waits in its final cycle if that register is still occupied.
`default_nettype none

module sliding_window_median_3axis (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  swm3_pos_if.sink  pos_i,
  swm3_med_if.source med_o,
  swm3_cfg_if.sink  cfg_i
);

  swm3_pkg::ctrl_cmd_t  cmd;
  swm3_pkg::dp_status_t status;
  swm3_pkg::sample_t    sample;
  swm3_pkg::sample_t    med;
  logic                 in_ready;

  assign sample[0] = pos_i.pos_x;
  assign sample[1] = pos_i.pos_y;
  assign sample[2] = pos_i.pos_z;
  assign pos_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  swm3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pos_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swm3_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (sample),
    .cfg_we_i    (cfg_i.valid),
    .cfg_len_i   (cfg_i.window_length),
    .out_valid_o (med_o.valid),
    .out_ready_i (med_o.ready),
    .med_o       (med),
    .fill_o      (med_o.window_fill)
  );

  assign med_o.med_x = med[0];
  assign med_o.med_y = med[1];
  assign med_o.med_z = med[2];

endmodule

`default_nettype wire

FILE: rtl/swm3_ctrl.sv
`default_nettype none

module swm3_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire swm3_pkg::dp_status_t status_i,
  output      swm3_pkg::ctrl_cmd_t  cmd_o
);

  swm3_pkg::state_e               state_q, state_d;
  logic [swm3_pkg::IdxW-1:0]      cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swm3_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      swm3_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = swm3_pkg::S_LOAD;
        end
      end
      swm3_pkg::S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = swm3_pkg::S_SORT;
      end
      swm3_pkg::S_SORT: begin
        cmd_o.sort     = 1'b1;
        cmd_o.sort_odd = cnt_q[0];
        if (cnt_q == swm3_pkg::IdxW'(swm3_pkg::MaxWindow - 1)) begin
          cnt_d   = '0;
          state_d = swm3_pkg::S_SEL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      swm3_pkg::S_SEL: begin
        if (cnt_q == status_i.sel_idx) begin
          state_d = swm3_pkg::S_FIN;
        end else begin
          cmd_o.shift = 1'b1;
          cnt_d       = cnt_q + 1'b1;
        end
      end
      swm3_pkg::S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = swm3_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = swm3_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/swm3_datapath.sv
`default_nettype none

module swm3_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire swm3_pkg::ctrl_cmd_t            cmd_i,
  output      swm3_pkg::dp_status_t           status_o,
  input  wire swm3_pkg::sample_t              sample_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [swm3_pkg::LenW-1:0]      cfg_len_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      swm3_pkg::sample_t              med_o,
  output      logic [swm3_pkg::FillW-1:0]     fill_o
);

  logic [swm3_pkg::LenW-1:0] win_len_q;
  logic [swm3_pkg::CntW-1:0] fill_q, fill_d;
  logic [swm3_pkg::CmpW-1:0] len_ext, inc_ext, limit_ext;
  logic [swm3_pkg::CntW-1:0] fill_inc;

  swm3_pkg::sample_t head_q;
  swm3_pkg::sample_t tail_q [swm3_pkg::TailN];
  swm3_pkg::sample_t win    [swm3_pkg::MaxWindow];

  swm3_pkg::key_t work_q      [swm3_pkg::MaxWindow];
  swm3_pkg::key_t work_sorted [swm3_pkg::MaxWindow];
  swm3_pkg::key_t work_shift  [swm3_pkg::MaxWindow];

  logic                    out_valid_q;
  swm3_pkg::sample_t       med_q, med_d;
  logic [swm3_pkg::FillW-1:0] fill_out_q;

  logic [swm3_pkg::DataW-1:0] lo_v, hi_v;
  logic [swm3_pkg::DataW:0]   pair_sum;
  logic [swm3_pkg::CntW-1:0]  fill_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= swm3_pkg::LenReset;
    end else if (cfg_we_i) begin
      win_len_q <= cfg_len_i;
    end
  end

  // The window may never exceed the configured length nor the store depth.
  always_comb begin
    len_ext  = swm3_pkg::CmpW'(win_len_q);
    fill_inc = (fill_q == swm3_pkg::CntW'(swm3_pkg::MaxWindow)) ? fill_q : fill_q + 1'b1;
    inc_ext  = swm3_pkg::CmpW'(fill_inc);
    if (len_ext == '0) begin
      limit_ext = swm3_pkg::CmpW'(1);
    end else if (len_ext > swm3_pkg::CmpW'(swm3_pkg::MaxWindow)) begin
      limit_ext = swm3_pkg::CmpW'(swm3_pkg::MaxWindow);
    end else begin
      limit_ext = len_ext;
    end
    fill_d = (inc_ext > limit_ext) ? swm3_pkg::CntW'(limit_ext) : fill_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= swm3_pkg::CntW'(1);
      head_q <= '0;
    end else if (cmd_i.accept) begin
      fill_q <= fill_d;
      head_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tail_q[0] <= head_q;
      for (int p = 1; p < swm3_pkg::TailN; p++) begin
        tail_q[p] <= tail_q[p-1];
      end
    end
  end

  always_comb begin
    win[0] = head_q;
    for (int p = 1; p < swm3_pkg::MaxWindow; p++) begin
      win[p] = tail_q[p-1];
    end
  end

  // Sort keys put slots beyond the fill count above every real sample, and
  // flip the sign bit so that an unsigned compare orders signed values.
  always_comb begin
    for (int p = 0; p < swm3_pkg::MaxWindow; p++) begin
      work_sorted[p] = work_q[p];
      work_shift[p]  = (p < swm3_pkg::MaxWindow - 1) ? work_q[(p + 1) % swm3_pkg::MaxWindow]
                                                     : work_q[p];
    end
    for (int p = 0; p < swm3_pkg::MaxWindow - 1; p++) begin
      if (p[0] == cmd_i.sort_odd) begin
        for (int a = 0; a < swm3_pkg::NumAxes; a++) begin
          if (work_q[p][a] > work_q[p+1][a]) begin
            work_sorted[p][a]   = work_q[p+1][a];
            work_sorted[p+1][a] = work_q[p][a];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int p = 0; p < swm3_pkg::MaxWindow; p++) begin
        for (int a = 0; a < swm3_pkg::NumAxes; a++) begin
          work_q[p][a] <= {(swm3_pkg::CntW'(p) >= fill_q), ~win[p][a][swm3_pkg::DataW-1],
                           win[p][a][swm3_pkg::DataW-2:0]};
        end
      end
    end else if (cmd_i.sort) begin
      work_q <= work_sorted;
    end else if (cmd_i.shift) begin
      work_q <= work_shift;
    end
  end

  always_comb begin
    fill_m1 = fill_q - 1'b1;
    med_d   = '0;
    lo_v    = '0;
    hi_v    = '0;
    pair_sum = '0;
    for (int a = 0; a < swm3_pkg::NumAxes; a++) begin
      lo_v = {~work_q[0][a][swm3_pkg::DataW-1], work_q[0][a][swm3_pkg::DataW-2:0]};
      hi_v = {~work_q[swm3_pkg::HiPos][a][swm3_pkg::DataW-1],
              work_q[swm3_pkg::HiPos][a][swm3_pkg::DataW-2:0]};
      pair_sum = {lo_v[swm3_pkg::DataW-1], lo_v} + {hi_v[swm3_pkg::DataW-1], hi_v};
      med_d[a] = fill_q[0] ? lo_v : pair_sum[swm3_pkg::DataW:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      med_q      <= med_d;
      fill_out_q <= swm3_pkg::FillW'(fill_q);
    end
  end

  assign status_o.sel_idx  = swm3_pkg::IdxW'(fill_m1 >> 1);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign med_o             = med_q;
  assign fill_o            = fill_out_q;

endmodule

`default_nettype wire
